@@ rtl/hpa_pkg.sv @@
package hpa_pkg;

    // Fixed-point scale points: hue in Q9.12 degrees, saturation and value in Q1.16.
    localparam logic [17:0] DEG60  = 18'd245760;
    localparam logic [20:0] DEG360 = 21'd1474560;
    localparam logic [16:0] ONE    = 17'd65536;

    // Pipelined divider geometry. Numerators of both quotients fit in 26 bits.
    localparam int DIV_NUM_W     = 26;
    localparam int DIV_DEN_W     = 8;
    localparam int DIV_STEP_BITS = 4;

    // Reciprocals for division by constants: floor(2^40 / 1000) and floor(2^28 / 15).
    localparam logic [30:0] RECIP_1000 = 31'd1099511627;
    localparam int          RECIP_1000_SH = 40;
    localparam logic [24:0] RECIP_15   = 25'd17895697;
    localparam int          RECIP_15_SH = 28;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_SHIFT  = 2'd0,
        CFG_SAT_GAIN   = 2'd1,
        CFG_VALUE_GAIN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [9:0] hue_shift;
        logic [11:0]       sat_gain;
        logic [11:0]       value_gain;
    } t_cfg;

endpackage

@@ rtl/hsv_pixel_adjust.sv @@
// Channel      | Direction | Beat contents
// -------------+-----------+---------------------------------------------------
// s_axis       | in        | tdata: red_in, green_in, blue_in; tlast: last_pixel_in
// m_axis       | out       | tdata: red_out, green_out, blue_out; tlast: last_pixel_out
// cfg write    | in        | index 0 hue_shift, 1 sat_gain, 2 value_gain
//
// One pixel beat is accepted per clock while s_axis tready is high. With the
// default divider step of four quotient bits per stage, the two dividers have
// seven stages each and sit between the numerator register and G1.
// Reset is synchronous and active low; it clears valid bits and loads the
// register defaults (no shift, unity gains).
// A stalled output fills a one-beat spare slot; only then does s_axis tready drop.
module hsv_pixel_adjust import hpa_pkg::*; #(
    parameter int P_DIV_STEP = DIV_STEP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Pixel input.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,  // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic                  i_s_axis_tlast,
    // Pixel output.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [23:0]           o_m_axis_tdata,  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic                  o_m_axis_tlast,
    // Register writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Which channel was largest; it picks the hue formula and base angle.
    typedef enum logic [1:0] {
        HB_RED   = 2'd0,
        HB_GREEN = 2'd1,
        HB_BLUE  = 2'd2
    } t_hue_base;

    typedef struct packed {
        logic [16:0] v;
        logic        hue_zero;
        logic        sat_zero;
        t_hue_base   base;
        logic        neg;
    } t_div_pay;

    // Shift plus 512 times 4096 is always positive; this bias adds the rest of
    // two full turns so the sum never goes negative before the wrap.
    localparam logic [22:0] HUE_BIAS = 23'd851968;

    t_cfg w_cfg;
    logic w_ce;

    hpa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_s_axis_tready = w_ce;

    // ---------------------------------------------------------------- input register
    logic       r_s0_v;
    logic [7:0] r_s0_r, r_s0_g, r_s0_b;
    logic       r_s0_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_ce) begin
            r_s0_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s0_r    <= i_s_axis_tdata[7:0];
            r_s0_g    <= i_s_axis_tdata[15:8];
            r_s0_b    <= i_s_axis_tdata[23:16];
            r_s0_last <= i_s_axis_tlast;
        end
    end

    // ---------------------------------------------------------------- max, min, numerators
    // Value is ceil(mx * 65536 / 255), which is exactly 257 * mx plus one for any
    // nonzero mx. Hue numerator carries the half-divisor so the divider rounds.
    logic [7:0]           w_mx, w_mn, w_d, w_mag;
    logic signed [8:0]    w_diff;
    t_hue_base            w_base;
    logic [DIV_NUM_W-1:0] w_num_s, w_num_h;

    always_comb begin
        w_mx = r_s0_r;
        if (r_s0_g > w_mx) w_mx = r_s0_g;
        if (r_s0_b > w_mx) w_mx = r_s0_b;
        w_mn = r_s0_r;
        if (r_s0_g < w_mn) w_mn = r_s0_g;
        if (r_s0_b < w_mn) w_mn = r_s0_b;
        w_d = w_mx - w_mn;
        if (w_mx == r_s0_r) begin
            w_base = HB_RED;
            w_diff = $signed({1'b0, r_s0_g}) - $signed({1'b0, r_s0_b});
        end else if (w_mx == r_s0_g) begin
            w_base = HB_GREEN;
            w_diff = $signed({1'b0, r_s0_b}) - $signed({1'b0, r_s0_r});
        end else begin
            w_base = HB_BLUE;
            w_diff = $signed({1'b0, r_s0_r}) - $signed({1'b0, r_s0_g});
        end
        w_mag   = w_diff[8] ? 8'(-w_diff) : w_diff[7:0];
        w_num_s = DIV_NUM_W'({w_d, 16'd0}) + DIV_NUM_W'(w_mx >> 1);
        w_num_h = DIV_NUM_W'({12'(w_mag) * 12'd15, 14'd0}) + DIV_NUM_W'(w_d >> 1);
    end

    logic                 r_s1_v;
    logic [DIV_NUM_W-1:0] r_s1_num_s, r_s1_num_h;
    logic [7:0]           r_s1_mx, r_s1_d;
    t_div_pay             r_s1_pay;
    logic                 r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_ce) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s1_num_s        <= w_num_s;
            r_s1_num_h        <= w_num_h;
            r_s1_mx           <= w_mx;
            r_s1_d            <= w_d;
            r_s1_pay.v        <= (17'(w_mx) * 17'd257) + 17'(w_mx != 8'd0);
            r_s1_pay.hue_zero <= (w_d == 8'd0);
            r_s1_pay.sat_zero <= (w_mx == 8'd0);
            r_s1_pay.base     <= w_base;
            r_s1_pay.neg      <= w_diff[8];
            r_s1_last         <= r_s0_last;
        end
    end

    // ---------------------------------------------------------------- dividers
    // Saturation: (d*65536 + mx/2) / mx. Hue: (|num|*245760 + d/2) / d.
    // A zero divisor gives garbage that the flags below replace with zero.
    logic                 w_divs_v, w_divh_v;
    logic [DIV_NUM_W-1:0] w_quo_s, w_quo_h;
    logic                 w_divs_last;
    t_div_pay             w_divh_pay;

    hpa_div #(
        .NUM_W     (DIV_NUM_W),
        .DEN_W     (DIV_DEN_W),
        .STEP_BITS (P_DIV_STEP),
        .PAY_W     (1)
    ) u_div_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_s1_v),
        .i_num   (r_s1_num_s),
        .i_den   (r_s1_mx),
        .i_pay   (r_s1_last),
        .o_valid (w_divs_v),
        .o_quo   (w_quo_s),
        .o_pay   (w_divs_last)
    );

    hpa_div #(
        .NUM_W     (DIV_NUM_W),
        .DEN_W     (DIV_DEN_W),
        .STEP_BITS (P_DIV_STEP),
        .PAY_W     ($bits(t_div_pay))
    ) u_div_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_s1_v),
        .i_num   (r_s1_num_h),
        .i_den   (r_s1_d),
        .i_pay   (r_s1_pay),
        .o_valid (w_divh_v),
        .o_quo   (w_quo_h),
        .o_pay   (w_divh_pay)
    );

    // ---------------------------------------------------------------- G1: gains multiply, hue sum
    logic [16:0] w_sat;
    logic [20:0] w_off, w_hue;
    logic [22:0] w_hsum;

    always_comb begin
        w_sat = w_divh_pay.sat_zero ? 17'd0 : w_quo_s[16:0];
        case (w_divh_pay.base)
            HB_RED:   w_off = w_divh_pay.neg ? DEG360 : 21'd0;
            HB_GREEN: w_off = 21'(DEG60) * 21'd2;
            default:  w_off = 21'(DEG60) * 21'd4;
        endcase
        if (w_divh_pay.hue_zero) begin
            w_hue = 21'd0;
        end else if (w_divh_pay.neg) begin
            w_hue = w_off - 21'(w_quo_h[17:0]);
        end else begin
            w_hue = w_off + 21'(w_quo_h[17:0]);
        end
        w_hsum = 23'(w_hue) + 23'({~w_cfg.hue_shift[9], w_cfg.hue_shift[8:0], 12'd0})
               + HUE_BIAS;
    end

    logic        r_g1_v;
    logic [28:0] r_g1_ps, r_g1_pv;
    logic [22:0] r_g1_hsum;
    logic        r_g1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_v <= 1'b0;
        end else if (w_ce) begin
            r_g1_v <= w_divh_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g1_ps   <= 29'(w_sat) * 29'(w_cfg.sat_gain);
            r_g1_pv   <= 29'(w_divh_pay.v) * 29'(w_cfg.value_gain);
            r_g1_hsum <= w_hsum;
            r_g1_last <= w_divs_last;
        end
    end

    // ---------------------------------------------------------------- G2: divide by 1000, hue wrap
    // The reciprocal estimate is the true quotient or one below it.
    logic [28:0] w_xs, w_xv;
    logic [59:0] w_prod_s, w_prod_v;
    logic [22:0] w_wrap;

    always_comb begin
        w_xs     = r_g1_ps + 29'd500;
        w_xv     = r_g1_pv + 29'd500;
        w_prod_s = 60'(w_xs) * 60'(RECIP_1000);
        w_prod_v = 60'(w_xv) * 60'(RECIP_1000);
        w_wrap   = r_g1_hsum;
        if (w_wrap >= 23'(DEG360) * 23'd4) w_wrap = w_wrap - 23'(DEG360) * 23'd4;
        if (w_wrap >= 23'(DEG360) * 23'd2) w_wrap = w_wrap - 23'(DEG360) * 23'd2;
        if (w_wrap >= 23'(DEG360))         w_wrap = w_wrap - 23'(DEG360);
    end

    logic        r_g2_v;
    logic [28:0] r_g2_xs, r_g2_xv;
    logic [19:0] r_g2_qs, r_g2_qv;
    logic [20:0] r_g2_hue;
    logic        r_g2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g2_v <= 1'b0;
        end else if (w_ce) begin
            r_g2_v <= r_g1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g2_xs   <= w_xs;
            r_g2_xv   <= w_xv;
            r_g2_qs   <= w_prod_s[RECIP_1000_SH +: 20];
            r_g2_qv   <= w_prod_v[RECIP_1000_SH +: 20];
            r_g2_hue  <= w_wrap[20:0];
            r_g2_last <= r_g1_last;
        end
    end

    // ---------------------------------------------------------------- G3: correct, clamp, sextant
    function automatic logic [16:0] gain_fix(input logic [28:0] x, input logic [19:0] q0);
        logic [29:0] rem;
        logic [19:0] q;
        rem = 30'(x) - (30'(q0) * 30'd1000);
        q   = q0 + 20'(rem >= 30'd1000);
        return (q > 20'(ONE)) ? ONE : q[16:0];
    endfunction

    logic [2:0]  w_k;
    logic [17:0] w_f;

    always_comb begin
        w_k = 3'd0;
        for (int n = 1; n < 6; n++) begin
            if (r_g2_hue >= 21'(DEG60) * 21'(n)) w_k = 3'(n);
        end
        w_f = 18'(r_g2_hue - 21'(DEG60) * 21'(w_k));
    end

    logic        r_g3_v;
    logic [16:0] r_g3_s, r_g3_val;
    logic [2:0]  r_g3_k;
    logic [17:0] r_g3_f;
    logic        r_g3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g3_v <= 1'b0;
        end else if (w_ce) begin
            r_g3_v <= r_g2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g3_s    <= gain_fix(r_g2_xs, r_g2_qs);
            r_g3_val  <= gain_fix(r_g2_xv, r_g2_qv);
            r_g3_k    <= w_k;
            r_g3_f    <= w_f;
            r_g3_last <= r_g2_last;
        end
    end

    // ---------------------------------------------------------------- G4: chroma
    logic [32:0] w_vs;

    assign w_vs = (33'(r_g3_val) * 33'(r_g3_s)) + 33'd32768;

    logic        r_g4_v;
    logic [16:0] r_g4_c, r_g4_val;
    logic [17:0] r_g4_xn;
    logic [2:0]  r_g4_k;
    logic        r_g4_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g4_v <= 1'b0;
        end else if (w_ce) begin
            r_g4_v <= r_g3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g4_c    <= w_vs[32:16];
            r_g4_val  <= r_g3_val;
            r_g4_xn   <= r_g3_k[0] ? (DEG60 - r_g3_f) : r_g3_f;
            r_g4_k    <= r_g3_k;
            r_g4_last <= r_g3_last;
        end
    end

    // ---------------------------------------------------------------- G5: offset, secondary product
    logic        r_g5_v;
    logic [34:0] r_g5_p;
    logic [16:0] r_g5_c, r_g5_m;
    logic [2:0]  r_g5_k;
    logic        r_g5_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g5_v <= 1'b0;
        end else if (w_ce) begin
            r_g5_v <= r_g4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g5_p    <= 35'(r_g4_c) * 35'(r_g4_xn);
            r_g5_c    <= r_g4_c;
            r_g5_m    <= r_g4_val - r_g4_c;
            r_g5_k    <= r_g4_k;
            r_g5_last <= r_g4_last;
        end
    end

    // ---------------------------------------------------------------- G6: divide by 245760
    // 245760 is 15 * 2^14: shift first, then divide by 15 through a reciprocal.
    logic [34:0] w_pr;
    logic [20:0] w_y;
    logic [45:0] w_yp;

    always_comb begin
        w_pr = r_g5_p + 35'(DEG60 >> 1);
        w_y  = w_pr[34:14];
        w_yp = 46'(w_y) * 46'(RECIP_15);
    end

    logic        r_g6_v;
    logic [20:0] r_g6_y;
    logic [17:0] r_g6_q;
    logic [16:0] r_g6_c, r_g6_m;
    logic [2:0]  r_g6_k;
    logic        r_g6_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g6_v <= 1'b0;
        end else if (w_ce) begin
            r_g6_v <= r_g5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g6_y    <= w_y;
            r_g6_q    <= w_yp[RECIP_15_SH +: 18];
            r_g6_c    <= r_g5_c;
            r_g6_m    <= r_g5_m;
            r_g6_k    <= r_g5_k;
            r_g6_last <= r_g5_last;
        end
    end

    // ---------------------------------------------------------------- G7: sextant pattern
    logic [21:0] w_rem15;
    logic [16:0] w_x;
    logic [16:0] w_ch_r, w_ch_g, w_ch_b;

    always_comb begin
        w_rem15 = 22'(r_g6_y) - (22'(r_g6_q) * 22'd15);
        w_x     = 17'(r_g6_q) + 17'(w_rem15 >= 22'd15);
        case (r_g6_k)
            3'd0:    begin w_ch_r = r_g6_c; w_ch_g = w_x;    w_ch_b = 17'd0;  end
            3'd1:    begin w_ch_r = w_x;    w_ch_g = r_g6_c; w_ch_b = 17'd0;  end
            3'd2:    begin w_ch_r = 17'd0;  w_ch_g = r_g6_c; w_ch_b = w_x;    end
            3'd3:    begin w_ch_r = 17'd0;  w_ch_g = w_x;    w_ch_b = r_g6_c; end
            3'd4:    begin w_ch_r = w_x;    w_ch_g = 17'd0;  w_ch_b = r_g6_c; end
            default: begin w_ch_r = r_g6_c; w_ch_g = 17'd0;  w_ch_b = w_x;    end
        endcase
    end

    logic        r_g7_v;
    logic [16:0] r_g7_r, r_g7_g, r_g7_b;
    logic        r_g7_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g7_v <= 1'b0;
        end else if (w_ce) begin
            r_g7_v <= r_g6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g7_r    <= w_ch_r + r_g6_m;
            r_g7_g    <= w_ch_g + r_g6_m;
            r_g7_b    <= w_ch_b + r_g6_m;
            r_g7_last <= r_g6_last;
        end
    end

    // ---------------------------------------------------------------- G8: back to bytes
    // floor(x * 255 / 65536), saturated at 255.
    function automatic logic [7:0] to_byte(input logic [16:0] x);
        logic [24:0] z;
        z = {x, 8'd0} - 25'(x);
        return (z[24:16] > 9'd255) ? 8'd255 : z[23:16];
    endfunction

    logic        r_g8_v;
    logic [7:0]  r_g8_r, r_g8_g, r_g8_b;
    logic        r_g8_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g8_v <= 1'b0;
        end else if (w_ce) begin
            r_g8_v <= r_g7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g8_r    <= to_byte(r_g7_r);
            r_g8_g    <= to_byte(r_g7_g);
            r_g8_b    <= to_byte(r_g7_b);
            r_g8_last <= r_g7_last;
        end
    end

    // ---------------------------------------------------------------- output register and spare slot
    logic [24:0] w_out;

    hpa_skid #(
        .W (25)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_g8_v),
        .i_data  ({r_g8_last, r_g8_b, r_g8_g, r_g8_r}),
        .o_ce    (w_ce),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = w_out[23:0];
    assign o_m_axis_tlast = w_out[24];

    // ---------------------------------------------------------------- assertions
    // Both dividers see the same beats, so their valid outputs must agree.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_divs_v == w_divh_v)
        else $error("divider valid bits disagree");

    // Input is only held off while a finished pixel is waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no pending output");

    // The wrapped hue must fall in one of six sextants.
    a_sextant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g3_v |-> (r_g3_k <= 3'd5) && (r_g3_f < DEG60))
        else $error("hue sextant out of range");

endmodule

@@ rtl/hpa_div.sv @@
module hpa_div import hpa_pkg::*; #(
    parameter int NUM_W     = DIV_NUM_W,
    parameter int DEN_W     = DIV_DEN_W,
    parameter int STEP_BITS = DIV_STEP_BITS,
    parameter int PAY_W     = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [PAY_W-1:0] o_pay
);

    localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = STAGES * STEP_BITS;

    // Numerator bits shift out at the top while quotient bits shift in at the bottom.
    logic [PAD_W-1:0] w_nq  [STAGES+1];
    logic [DEN_W-1:0] w_rem [STAGES+1];
    logic [DEN_W-1:0] w_den [STAGES+1];
    logic [PAY_W-1:0] w_pay [STAGES+1];
    logic             w_v   [STAGES+1];

    assign w_nq[0]  = PAD_W'(i_num);
    assign w_rem[0] = '0;
    assign w_den[0] = i_den;
    assign w_pay[0] = i_pay;
    assign w_v[0]   = i_valid;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [PAD_W-1:0] n_nq;
        logic [DEN_W-1:0] n_rem;
        logic [PAD_W-1:0] r_nq;
        logic [DEN_W-1:0] r_rem;
        logic [DEN_W-1:0] r_den;
        logic [PAY_W-1:0] r_pay;
        logic             r_v;

        always_comb begin
            logic [DEN_W:0] v_trial;
            n_nq  = w_nq[s];
            n_rem = w_rem[s];
            for (int i = 0; i < STEP_BITS; i++) begin
                v_trial = {n_rem, n_nq[PAD_W-1]};
                n_nq    = {n_nq[PAD_W-2:0], 1'b0};
                if (v_trial >= {1'b0, w_den[s]}) begin
                    v_trial = v_trial - {1'b0, w_den[s]};
                    n_nq[0] = 1'b1;
                end
                n_rem = v_trial[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_ce) begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_nq  <= n_nq;
                r_rem <= n_rem;
                r_den <= w_den[s];
                r_pay <= w_pay[s];
            end
        end

        assign w_nq[s+1]  = r_nq;
        assign w_rem[s+1] = r_rem;
        assign w_den[s+1] = r_den;
        assign w_pay[s+1] = r_pay;
        assign w_v[s+1]   = r_v;
    end

    assign o_valid = w_v[STAGES];
    assign o_quo   = w_nq[STAGES][NUM_W-1:0];
    assign o_pay   = w_pay[STAGES];

endmodule

@@ rtl/hpa_cfg.sv @@
module hpa_cfg import hpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HUE_SHIFT:  n_cfg.hue_shift  = i_cfg_data[9:0];
                CFG_SAT_GAIN:   n_cfg.sat_gain   = i_cfg_data;
                CFG_VALUE_GAIN: n_cfg.value_gain = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_shift  <= 10'sd0;
            r_cfg.sat_gain   <= 12'd1000;
            r_cfg.value_gain <= 12'd1000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/hpa_skid.sv @@
module hpa_skid #(
    parameter int W = 25
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_ce,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);

    logic         r_out_v;
    logic [W-1:0] r_out;
    logic         r_skid_v;
    logic [W-1:0] r_skid;

    // The pipeline moves whenever the spare slot is empty.
    assign o_ce    = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_valid;
            end
        end else if (i_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (!r_skid_v) begin
            r_skid <= i_data;
        end
    end

endmodule
